### rtl/ncir_pkg.sv
// Shared constants, types and helpers for the nearest case insert/replace block.
`default_nettype none
package ncir_pkg;
  localparam int unsigned CaseSlots = 64;
  localparam int unsigned FeatW = 16;
  localparam int unsigned DistW = 64;
  localparam logic [15:0] WeightPosReset = 16'd256;
  localparam logic [15:0] WeightRangeReset = 16'd256;
  localparam logic [15:0] ThresholdReset = 16'd50;

  typedef enum logic [1:0] {
    ACT_APPEND  = 2'd0,
    ACT_REPLACE = 2'd1,
    ACT_DISCARD = 2'd2,
    ACT_DROP    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_WEIGHT_POS   = 2'd0,
    REG_WEIGHT_RANGE = 2'd1,
    REG_THRESHOLD    = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] r;
    logic [15:0] e;
  } case_t;

  // Unsigned magnitude of the 17-bit difference of two signed features.
  function automatic logic [16:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
    logic signed [16:0] d;
    d = $signed({a[15], a}) - $signed({b[15], b});
    abs_diff = d[16] ? 17'(-d) : 17'(d);
  endfunction
endpackage
`default_nettype wire

### rtl/ncir_cell.sv
// One storage cell of the case chain; the chain rotates its contents during a scan.
`default_nettype none
module ncir_cell (
  input  wire logic                 clk,
  input  wire logic                 shift,
  input  wire logic                 load,
  input  wire ncir_pkg::case_t      load_data,
  input  wire ncir_pkg::case_t      prev_data,
  output ncir_pkg::case_t           data
);
  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end else if (shift) begin
      data <= prev_data;
    end
  end
endmodule
`default_nettype wire

### rtl/ncir_dist.sv
// Pipelined weighted squared distance between the new case and one stored case.
`default_nettype none
module ncir_dist (
  input  wire logic            clk,
  input  wire ncir_pkg::case_t nc,
  input  wire ncir_pkg::case_t sc,
  input  wire logic [15:0]     w_pos,
  input  wire logic [15:0]     w_rng,
  output logic [63:0]          dist_sq
);
  logic [16:0] dx, dy, dr;
  logic [32:0] px, py, pr;
  logic [65:0] sx, sy, sr;
  logic [66:0] sum;

  always_ff @(posedge clk) begin
    dx <= ncir_pkg::abs_diff(nc.x, sc.x);
    dy <= ncir_pkg::abs_diff(nc.y, sc.y);
    dr <= ncir_pkg::abs_diff(nc.r, sc.r);
    px <= 33'(w_pos * dx);
    py <= 33'(w_pos * dy);
    pr <= 33'(w_rng * dr);
    sx <= 66'(px * px);
    sy <= 66'(py * py);
    sr <= 66'(pr * pr);
  end

  always_comb begin
    sum = 67'(sx) + 67'(sy) + 67'(sr);
    dist_sq = (sum[66:64] != 3'd0) ? {64{1'b1}} : sum[63:0];
  end
endmodule
`default_nettype wire

### rtl/nearest_case_insert_replace.sv
// Top level of the nearest case insert/replace block.
// Each item rotates the chain of stored cases once past a three-stage distance pipeline.
// busy stays high while the chain rotates, then while the pipeline drains until no valid
// distance is left in it, and through the decision; start is taken only while busy is low,
// so a new item is not accepted before the last one is through. The result appears on
// action, slot and case_count for one cycle with done high, in the first cycle after busy
// falls; the receiver cannot stall it.
`default_nettype none
module nearest_case_insert_replace #(
  parameter int unsigned CASE_SLOTS = ncir_pkg::CaseSlots
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] pos_x,
  input  wire logic [15:0] pos_y,
  input  wire logic [15:0] range_feature,
  input  wire logic [15:0] end_value,
  output logic             done,
  output logic [1:0]       action,
  output logic [5:0]       slot,
  output logic [6:0]       case_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int unsigned IdxW = $clog2(CASE_SLOTS);
  localparam int unsigned CntW = $clog2(CASE_SLOTS + 1);
  localparam int unsigned Lat = 3;

  ncir_pkg::state_t state, state_next;
  logic [15:0] w_pos, w_rng, thr;
  logic [CntW-1:0] count;
  ncir_pkg::case_t nc;
  ncir_pkg::case_t chain [CASE_SLOTS];
  logic [IdxW:0] step;
  logic [IdxW:0] tag_pipe [Lat];
  logic [Lat-1:0] vpipe;
  logic [63:0] dist_sq;
  logic [63:0] best_d;
  logic [IdxW-1:0] best;
  logic [15:0] best_end;
  logic [15:0] end_pipe [Lat];
  logic found;
  logic shift, load_any;
  logic [IdxW-1:0] wr_slot;
  logic [IdxW-1:0] wr_pos;
  logic [1:0] act;
  logic [CntW-1:0] count_next;
  logic [63:0] thr_sq;
  logic [31:0] thr_sh;
  logic decide_write;

  assign cfg_ready = 1'b1;
  assign busy = (state != ncir_pkg::ST_IDLE);
  assign shift = (state == ncir_pkg::ST_SCAN);

  always_ff @(posedge clk) begin
    if (rst) begin
      w_pos <= ncir_pkg::WeightPosReset;
      w_rng <= ncir_pkg::WeightRangeReset;
      thr <= ncir_pkg::ThresholdReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ncir_pkg::REG_WEIGHT_POS:   w_pos <= cfg_data;
        ncir_pkg::REG_WEIGHT_RANGE: w_rng <= cfg_data;
        ncir_pkg::REG_THRESHOLD:    thr <= cfg_data;
        default: ;
      endcase
    end
  end

  // After a full rotation chain[0] again holds slot 0; during the scan it holds slot step.
  ncir_dist u_dist (
    .clk(clk), .nc(nc), .sc(chain[0]), .w_pos(w_pos), .w_rng(w_rng), .dist_sq(dist_sq)
  );

  for (genvar g = 0; g < CASE_SLOTS; g++) begin : g_cell
    logic ld;
    assign ld = decide_write && (wr_pos == IdxW'(g));
    ncir_cell u_cell (
      .clk(clk), .shift(shift), .load(ld), .load_data(nc),
      .prev_data(chain[(g + 1) % CASE_SLOTS]), .data(chain[g])
    );
  end
  assign load_any = decide_write;
  assign wr_pos = wr_slot;

  always_ff @(posedge clk) begin
    tag_pipe[0] <= step;
    end_pipe[0] <= chain[0].e;
    for (int k = 1; k < Lat; k++) begin
      tag_pipe[k] <= tag_pipe[k-1];
      end_pipe[k] <= end_pipe[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[Lat-2:0], shift && (CntW'(step) < count)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ncir_pkg::ST_IDLE;
      count <= '0;
      step <= '0;
      found <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      if (state == ncir_pkg::ST_IDLE && start) begin
        step <= '0;
        found <= 1'b0;
      end
      if (shift) begin
        step <= step + 1'b1;
      end
      if (vpipe[Lat-1] && (!found || dist_sq < best_d)) begin
        found <= 1'b1;
      end
      if (state == ncir_pkg::ST_DECIDE) begin
        count <= count_next;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ncir_pkg::ST_IDLE && start) begin
      nc <= '{x: pos_x, y: pos_y, r: range_feature, e: end_value};
    end
    if (vpipe[Lat-1] && (!found || dist_sq < best_d)) begin
      best_d <= dist_sq;
      best <= tag_pipe[Lat-1][IdxW-1:0];
      best_end <= end_pipe[Lat-1];
    end
    if (state == ncir_pkg::ST_DECIDE) begin
      action <= act;
      slot <= 6'(wr_slot);
      case_count <= 7'(count_next);
    end
  end

  always_comb begin
    thr_sh = {8'd0, thr, 8'd0};
    thr_sq = 64'(thr_sh * thr_sh);
    count_next = count;
    wr_slot = best;
    act = ncir_pkg::ACT_DISCARD;
    decide_write = 1'b0;
    if (!found || best_d > thr_sq) begin
      if (count < CntW'(CASE_SLOTS)) begin
        act = ncir_pkg::ACT_APPEND;
        wr_slot = IdxW'(count);
        count_next = count + 1'b1;
        decide_write = (state == ncir_pkg::ST_DECIDE);
      end else begin
        act = ncir_pkg::ACT_DROP;
      end
    end else if (nc.e < best_end) begin
      act = ncir_pkg::ACT_REPLACE;
      decide_write = (state == ncir_pkg::ST_DECIDE);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ncir_pkg::ST_IDLE:   if (start) state_next = ncir_pkg::ST_SCAN;
      ncir_pkg::ST_SCAN:   if (step == (IdxW+1)'(CASE_SLOTS - 1)) state_next = ncir_pkg::ST_DRAIN;
      ncir_pkg::ST_DRAIN:  if (vpipe == '0) state_next = ncir_pkg::ST_DECIDE;
      ncir_pkg::ST_DECIDE: state_next = ncir_pkg::ST_IDLE;
      default:             state_next = ncir_pkg::ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(CASE_SLOTS)) else $error("case count exceeds table size");
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held longer than one cycle");
  a_no_write_outside: assert property (@(posedge clk) disable iff (rst)
    load_any |-> state == ncir_pkg::ST_DECIDE) else $error("table written outside decision");
  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (state == ncir_pkg::ST_DECIDE && act == ncir_pkg::ACT_APPEND)
    |=> count == $past(count) + 1'b1)
    else $error("append did not grow the table");
`endif
endmodule
`default_nettype wire
